// ===== sv/alrsd_pkg.sv =====
package alrsd_pkg;

    // APB register map: register i at byte address 4*i
    localparam int ADDR_W = 5;

    localparam logic [2:0] REG_POSITION_STEP = 3'd0;
    localparam logic [2:0] REG_NORMAL_WINDOW = 3'd1;
    localparam logic [2:0] REG_WIDE_POSITION = 3'd2;
    localparam logic [2:0] REG_WIDE_WINDOW   = 3'd3;
    localparam logic [2:0] REG_HIT_THRESHOLD = 3'd4;

    localparam logic [11:0] RST_POSITION_STEP = 12'd315;
    localparam logic [11:0] RST_NORMAL_WINDOW = 12'd110;
    localparam logic [3:0]  RST_WIDE_POSITION = 4'd5;
    localparam logic [11:0] RST_WIDE_WINDOW   = 12'd220;
    localparam logic [7:0]  RST_HIT_THRESHOLD = 8'd20;

    // depth of the hit-vector queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [11:0] position_step;
        logic [11:0] normal_window;
        logic [3:0]  wide_position;
        logic [11:0] wide_window;
        logic [7:0]  hit_threshold;
    } cfg_t;

    // handshake between the queue and its neighbors
    typedef struct packed {
        logic push;
        logic pop;
    } q_ctrl_t;

    typedef struct packed {
        logic full;
        logic valid;
    } q_stat_t;

endpackage

// ===== sv/alrsd_front.sv =====
module alrsd_front
    import alrsd_pkg::*;
#(
    parameter int POSITIONS   = 12,
    parameter int SAMPLE_BITS = 12
)
(
    input  cfg_t                   cfg,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   in_valid,
    input  logic                   q_full,
    output logic                   in_stall,
    output logic                   push,
    output logic [POSITIONS-1:0]   hits
);

    // expected reading (k+1)*step at full precision
    localparam int EXP_W = 12 + $clog2(POSITIONS + 1);
    localparam int DW    = (EXP_W > SAMPLE_BITS) ? EXP_W : SAMPLE_BITS;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        logic [DW-1:0] expected;
        logic [DW-1:0] smp;
        logic [DW-1:0] delta;
        logic [DW-1:0] win;
        smp = DW'(sample);
        for (int k = 0; k < POSITIONS; k++)
        begin
            expected = DW'(k + 1) * DW'(cfg.position_step);
            delta    = (expected > smp) ? (expected - smp) : (smp - expected);
            win      = (cfg.wide_position == 4'(k)) ? DW'(cfg.wide_window)
                                                    : DW'(cfg.normal_window);
            hits[k]  = (delta < win);
        end
    end

endmodule

// ===== sv/alrsd_queue.sv =====
module alrsd_queue
    import alrsd_pkg::*;
#(
    parameter int W     = 12,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  q_ctrl_t      ctrl,
    input  logic [W-1:0] wdata,
    output q_stat_t      stat,
    output logic [W-1:0] rdata
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.valid = (count_reg != '0);
    assign rdata      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (ctrl.push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (ctrl.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (ctrl.push && !ctrl.pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!ctrl.push && ctrl.pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== sv/alrsd_back.sv =====
module alrsd_back
    import alrsd_pkg::*;
#(
    parameter int POSITIONS = 12
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           hit_threshold,
    input  logic                 q_valid,
    input  logic [POSITIONS-1:0] hits,
    input  logic                 out_stall,
    output logic                 pop,
    output logic                 out_valid,
    output logic [3:0]           new_position
);

    localparam logic [8:0] COUNT_MAX = 9'd511;

    logic [8:0] cnt_reg  [POSITIONS];
    logic [8:0] cnt_next [POSITIONS];
    logic       known_reg;
    logic [3:0] pos_reg;
    logic       out_valid_reg;
    logic [3:0] out_pos_reg;

    logic       found;
    logic [3:0] win_idx;
    logic       emit;

    assign pop          = q_valid && (!out_valid_reg || !out_stall);
    assign emit         = found && (!known_reg || (pos_reg != win_idx));
    assign out_valid    = out_valid_reg;
    assign new_position = out_pos_reg;

    // first position over threshold wins; counters up to and including it are
    // cleared and later positions only see this sample's hit
    always_comb
    begin
        logic [8:0] inc_cnt;
        logic       cleared_before;
        found   = 1'b0;
        win_idx = '0;
        for (int k = 0; k < POSITIONS; k++)
        begin
            inc_cnt = cnt_reg[k] + 9'((hits[k] && (cnt_reg[k] != COUNT_MAX)) ? 1 : 0);
            cleared_before = found;
            if (!found && (inc_cnt > {1'b0, hit_threshold}))
            begin
                found   = 1'b1;
                win_idx = 4'(k);
            end
            if (cleared_before)
            begin
                cnt_next[k] = {8'd0, hits[k]};
            end
            else
            begin
                cnt_next[k] = inc_cnt;
            end
        end
        for (int k = 0; k < POSITIONS; k++)
        begin
            if (found && (k <= int'(win_idx)))
            begin
                cnt_next[k] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < POSITIONS; k++)
            begin
                cnt_reg[k] <= '0;
            end
            known_reg     <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_pos_reg   <= '0;
        end
        else
        begin
            if (pop)
            begin
                for (int k = 0; k < POSITIONS; k++)
                begin
                    cnt_reg[k] <= cnt_next[k];
                end
                if (found)
                begin
                    known_reg <= 1'b1;
                    pos_reg   <= win_idx;
                end
            end
            if (pop && emit)
            begin
                out_valid_reg <= 1'b1;
                out_pos_reg   <= win_idx;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== sv/adc_ladder_rotary_switch_debounce.sv =====
// Rotary switch decoder for a resistor ladder with hit-count debounce. Each
// input transaction carries one raw ADC sample; position k expects the reading
// (k+1)*position_step, and a sample closer than the half-window (wide_window for
// wide_position, normal_window otherwise) counts a hit for that position. When
// a position's hit count exceeds hit_threshold it becomes the switch position
// and the counters up to it clear (later ones keep only this sample's hit); an
// output transaction carrying new_position is sent only when the position
// actually changes. The block takes one sample per clock while the queue is
// not full: the front compares the sample against all positions in parallel,
// a two-entry queue holds the hit vectors, and the back updates every counter
// on each pop. A result passes the queue and then an output register, so input
// keeps flowing until both the output register and the queue are full.
// Registers live on an APB port at byte address 4*i; a threshold write of 0
// is stored as 1. Write them only while the block is idle.
module adc_ladder_rotary_switch_debounce
    import alrsd_pkg::*;
#(
    parameter int POSITIONS   = 12,
    parameter int SAMPLE_BITS = 12
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // sample channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [SAMPLE_BITS-1:0] sample,

    // result channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [3:0]             new_position,

    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    cfg_t                 cfg_reg;
    logic [2:0]           reg_sel;
    logic                 cfg_write;

    q_ctrl_t              q_ctrl;
    q_stat_t              q_stat;
    logic [POSITIONS-1:0] hits_in;
    logic [POSITIONS-1:0] hits_out;

    // ---- configuration registers ----
    assign pready    = 1'b1;
    assign reg_sel   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.position_step <= RST_POSITION_STEP;
            cfg_reg.normal_window <= RST_NORMAL_WINDOW;
            cfg_reg.wide_position <= RST_WIDE_POSITION;
            cfg_reg.wide_window   <= RST_WIDE_WINDOW;
            cfg_reg.hit_threshold <= RST_HIT_THRESHOLD;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_POSITION_STEP: cfg_reg.position_step <= pwdata[11:0];
                REG_NORMAL_WINDOW: cfg_reg.normal_window <= pwdata[11:0];
                REG_WIDE_POSITION: cfg_reg.wide_position <= pwdata[3:0];
                REG_WIDE_WINDOW:   cfg_reg.wide_window   <= pwdata[11:0];
                REG_HIT_THRESHOLD:
                begin
                    // a zero threshold would let a single hit change the position
                    cfg_reg.hit_threshold <= (pwdata[7:0] == 8'd0) ? 8'd1 : pwdata[7:0];
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_POSITION_STEP: prdata = {20'd0, cfg_reg.position_step};
            REG_NORMAL_WINDOW: prdata = {20'd0, cfg_reg.normal_window};
            REG_WIDE_POSITION: prdata = {28'd0, cfg_reg.wide_position};
            REG_WIDE_WINDOW:   prdata = {20'd0, cfg_reg.wide_window};
            REG_HIT_THRESHOLD: prdata = {24'd0, cfg_reg.hit_threshold};
            default:           prdata = 32'd0;
        endcase
    end

    // ---- front: window compares for every position ----
    alrsd_front #(
        .POSITIONS   (POSITIONS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .cfg      (cfg_reg),
        .sample   (sample),
        .in_valid (in_valid),
        .q_full   (q_stat.full),
        .in_stall (in_stall),
        .push     (q_ctrl.push),
        .hits     (hits_in)
    );

    // ---- queue of hit vectors ----
    alrsd_queue #(
        .W     (POSITIONS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (q_ctrl),
        .wdata (hits_in),
        .stat  (q_stat),
        .rdata (hits_out)
    );

    // ---- back: counters, position decision, output register ----
    alrsd_back #(
        .POSITIONS (POSITIONS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .hit_threshold (cfg_reg.hit_threshold),
        .q_valid       (q_stat.valid),
        .hits          (hits_out),
        .out_stall     (out_stall),
        .pop           (q_ctrl.pop),
        .out_valid     (out_valid),
        .new_position  (new_position)
    );

endmodule
